[hdl/ps2kd_pkg.sv]
// Package for the PS/2 set-1 scancode key decoder.
// Holds scancode constants, result kind codes and the ASCII lookup tables.
// No dependencies.
`default_nettype none

package ps2kd_pkg;

  // Widths fixed by the interface
  localparam int unsigned SCAN_W = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TERM_W = 3;
  localparam int unsigned MASK_W = 6;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Default terminal count
  localparam int unsigned TERMINALS_DEF = 6;

  // Register index of the raw mode mask
  localparam logic REG_RAW_MODE = 1'b0;

  // Scancodes
  localparam logic [7:0] SC_PREFIX    = 8'hE0;
  localparam logic [7:0] SC_LSHIFT    = 8'h2A;
  localparam logic [7:0] SC_RSHIFT    = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BR = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BR = 8'hB6;
  localparam logic [7:0] SC_CTRL      = 8'h1D;
  localparam logic [7:0] SC_CTRL_BR   = 8'h9D;
  localparam logic [7:0] SC_ALT       = 8'h38;
  localparam logic [7:0] SC_ALT_BR    = 8'hB8;
  localparam logic [7:0] SC_F1        = 8'h3B;
  localparam logic [7:0] SC_UP        = 8'h48;
  localparam logic [7:0] SC_PGUP      = 8'h49;
  localparam logic [7:0] SC_LEFT      = 8'h4B;
  localparam logic [7:0] SC_RIGHT     = 8'h4D;
  localparam logic [7:0] SC_HOME      = 8'h47;
  localparam logic [7:0] SC_END       = 8'h4F;
  localparam logic [7:0] SC_DOWN      = 8'h50;
  localparam logic [7:0] SC_PGDN      = 8'h51;
  localparam logic [7:0] SC_DELETE    = 8'h53;
  localparam logic [7:0] SC_TABLE_END = 8'd60;

  // Escape sequence bytes
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // Result kinds
  typedef enum logic [1:0] {
    EV_KEY         = 2'd0,
    EV_SWITCH      = 2'd1,
    EV_SCROLL_BACK = 2'd2,
    EV_SCROLL_FWD  = 2'd3
  } event_kind_e;

  // Third byte of the ANSI sequence for an extended key (the digit 3 for Delete), zero if none
  function automatic logic [7:0] ansi_letter(input logic [7:0] sc);
    logic [7:0] r;
    r = 8'h00;
    case (sc)
      SC_UP:     r = 8'h41;
      SC_DOWN:   r = 8'h42;
      SC_RIGHT:  r = 8'h43;
      SC_LEFT:   r = 8'h44;
      SC_HOME:   r = 8'h48;
      SC_END:    r = 8'h46;
      SC_DELETE: r = CH_THREE;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

  // Plain / shifted ASCII table for make codes below 60
  function automatic logic [7:0] ascii_map(input logic [5:0] idx, input logic shifted);
    logic [7:0] p;
    logic [7:0] s;
    p = 8'h00;
    s = 8'h00;
    case (idx)
      6'd1:  begin p = 8'h1B; s = 8'h1B; end
      6'd2:  begin p = 8'h31; s = 8'h21; end
      6'd3:  begin p = 8'h32; s = 8'h40; end
      6'd4:  begin p = 8'h33; s = 8'h23; end
      6'd5:  begin p = 8'h34; s = 8'h24; end
      6'd6:  begin p = 8'h35; s = 8'h25; end
      6'd7:  begin p = 8'h36; s = 8'h5E; end
      6'd8:  begin p = 8'h37; s = 8'h26; end
      6'd9:  begin p = 8'h38; s = 8'h2A; end
      6'd10: begin p = 8'h39; s = 8'h28; end
      6'd11: begin p = 8'h30; s = 8'h29; end
      6'd12: begin p = 8'h2D; s = 8'h5F; end
      6'd13: begin p = 8'h3D; s = 8'h2B; end
      6'd14: begin p = 8'h08; s = 8'h08; end
      6'd15: begin p = 8'h09; s = 8'h09; end
      6'd16: begin p = 8'h71; s = 8'h51; end
      6'd17: begin p = 8'h77; s = 8'h57; end
      6'd18: begin p = 8'h65; s = 8'h45; end
      6'd19: begin p = 8'h72; s = 8'h52; end
      6'd20: begin p = 8'h74; s = 8'h54; end
      6'd21: begin p = 8'h79; s = 8'h59; end
      6'd22: begin p = 8'h75; s = 8'h55; end
      6'd23: begin p = 8'h69; s = 8'h49; end
      6'd24: begin p = 8'h6F; s = 8'h4F; end
      6'd25: begin p = 8'h70; s = 8'h50; end
      6'd26: begin p = 8'h5B; s = 8'h7B; end
      6'd27: begin p = 8'h5D; s = 8'h7D; end
      6'd28: begin p = 8'h0A; s = 8'h0A; end
      6'd30: begin p = 8'h61; s = 8'h41; end
      6'd31: begin p = 8'h73; s = 8'h53; end
      6'd32: begin p = 8'h64; s = 8'h44; end
      6'd33: begin p = 8'h66; s = 8'h46; end
      6'd34: begin p = 8'h67; s = 8'h47; end
      6'd35: begin p = 8'h68; s = 8'h48; end
      6'd36: begin p = 8'h6A; s = 8'h4A; end
      6'd37: begin p = 8'h6B; s = 8'h4B; end
      6'd38: begin p = 8'h6C; s = 8'h4C; end
      6'd39: begin p = 8'h3B; s = 8'h3A; end
      6'd40: begin p = 8'h27; s = 8'h22; end
      6'd41: begin p = 8'h60; s = 8'h7E; end
      6'd43: begin p = 8'h5C; s = 8'h7C; end
      6'd44: begin p = 8'h7A; s = 8'h5A; end
      6'd45: begin p = 8'h78; s = 8'h58; end
      6'd46: begin p = 8'h63; s = 8'h43; end
      6'd47: begin p = 8'h76; s = 8'h56; end
      6'd48: begin p = 8'h62; s = 8'h42; end
      6'd49: begin p = 8'h6E; s = 8'h4E; end
      6'd50: begin p = 8'h6D; s = 8'h4D; end
      6'd51: begin p = 8'h2C; s = 8'h3C; end
      6'd52: begin p = 8'h2E; s = 8'h3E; end
      6'd53: begin p = 8'h2F; s = 8'h3F; end
      6'd55: begin p = 8'h2A; s = 8'h2A; end
      6'd57: begin p = 8'h20; s = 8'h20; end
      default: begin p = 8'h00; s = 8'h00; end
    endcase
    return shifted ? s : p;
  endfunction

endpackage

`default_nettype wire

[hdl/ps2_scancode_key_decoder_unit.sv]
// Top level of the PS/2 set-1 scancode key decoder.
// Depends on ps2kd_pkg for scancodes, result kinds and ASCII tables.
`default_nettype none

// Takes one scancode byte per transfer into an input register, decodes it
// combinationally against the modifier, prefix and terminal state, and loads
// the resulting run of up to four results into an output run register, which
// hands them out one per cycle while the output is not stalled. A byte passes
// the input register and then the run register before its first result shows.
// Items that yield zero or one result stream at one per cycle while the output
// is not stalled; an escape sequence holds the run register until its three or
// four result bytes are handed out. A byte that yields results waits in the
// input register until the run register is free; it moves in the same cycle as
// the last result of the current run is transferred, so runs follow one
// another without a gap. The raw mode mask is written at APB addresses 0 to 3.
module ps2_scancode_key_decoder_unit #(
  parameter int unsigned TERMINALS = ps2kd_pkg::TERMINALS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Scancode input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [ps2kd_pkg::SCAN_W-1:0]     scan_byte_i,
  // Result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [1:0]                            event_kind_o,
  output logic [ps2kd_pkg::BYTE_W-1:0]          key_byte_o,
  output logic [ps2kd_pkg::TERM_W-1:0]          terminal_index_o,
  output logic                                  last_of_run_o,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ps2kd_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [ps2kd_pkg::PDATA_W-1:0]    pwdata,
  output logic [ps2kd_pkg::PDATA_W-1:0]         prdata,
  output logic                                  pready
);
  import ps2kd_pkg::*;

  // Configuration register
  logic [MASK_W-1:0] raw_mode_q;
  logic              cfg_wr;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_RAW_MODE);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? {{(PDATA_W-MASK_W){1'b0}}, raw_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q <= '0;
    end else if (cfg_wr) begin
      raw_mode_q <= pwdata[MASK_W-1:0];
    end
  end

  // Input register
  logic              in_valid_q;
  logic [SCAN_W-1:0] in_byte_q;
  logic              in_xfer;
  logic              go;

  assign in_stall_o = in_valid_q && !go;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= scan_byte_i;
    end
  end

  // Keyboard state
  logic              shift_q, shift_d;
  logic              ctrl_q, ctrl_d;
  logic              alt_q, alt_d;
  logic              prefix_q, prefix_d;
  logic [TERM_W-1:0] term_q, term_d;

  // Decode results
  logic [2:0]        n_res;
  event_kind_e       kind_d;
  logic [BYTE_W-1:0] bytes_d [4];

  logic [SCAN_W-1:0] fkey_off;
  logic              fkey_hit;
  logic [7:0]        raw_ext;
  logic              raw_on;
  logic [7:0]        letter;
  logic [7:0]        ascii;

  assign fkey_off = in_byte_q - SC_F1;
  assign fkey_hit = ctrl_q && alt_q && (in_byte_q >= SC_F1)
                    && (fkey_off < SCAN_W'(TERMINALS));
  assign raw_ext  = {{(8-MASK_W){1'b0}}, raw_mode_q};
  assign raw_on   = raw_ext[term_q];
  assign letter   = ansi_letter(in_byte_q);
  assign ascii    = ascii_map(in_byte_q[5:0], shift_q);

  // One-pass decode of the byte in the input register
  always_comb begin
    shift_d    = shift_q;
    ctrl_d     = ctrl_q;
    alt_d      = alt_q;
    prefix_d   = prefix_q;
    term_d     = term_q;
    n_res      = 3'd0;
    kind_d     = EV_KEY;
    bytes_d[0] = '0;
    bytes_d[1] = '0;
    bytes_d[2] = '0;
    bytes_d[3] = '0;
    if (in_byte_q == SC_PREFIX) begin
      prefix_d = 1'b1;
    end else if (in_byte_q == SC_LSHIFT || in_byte_q == SC_RSHIFT) begin
      prefix_d = 1'b0;
      shift_d  = 1'b1;
    end else if (in_byte_q == SC_LSHIFT_BR || in_byte_q == SC_RSHIFT_BR) begin
      prefix_d = 1'b0;
      shift_d  = 1'b0;
    end else if (in_byte_q == SC_CTRL) begin
      prefix_d = 1'b0;
      ctrl_d   = 1'b1;
    end else if (in_byte_q == SC_CTRL_BR) begin
      prefix_d = 1'b0;
      ctrl_d   = 1'b0;
    end else if (in_byte_q == SC_ALT) begin
      prefix_d = 1'b0;
      alt_d    = 1'b1;
    end else if (in_byte_q == SC_ALT_BR) begin
      prefix_d = 1'b0;
      alt_d    = 1'b0;
    end else if (fkey_hit) begin
      // terminal switch leaves the prefix flag alone
      term_d = fkey_off[TERM_W-1:0];
      n_res  = 3'd1;
      kind_d = EV_SWITCH;
    end else if (in_byte_q[7]) begin
      prefix_d = 1'b0;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      if (in_byte_q == SC_PGUP || (shift_q && in_byte_q == SC_UP)) begin
        n_res  = 3'd1;
        kind_d = EV_SCROLL_BACK;
      end else if (in_byte_q == SC_PGDN || (shift_q && in_byte_q == SC_DOWN)) begin
        n_res  = 3'd1;
        kind_d = EV_SCROLL_FWD;
      end else if (raw_on && letter != 8'h00) begin
        bytes_d[0] = CH_ESC;
        bytes_d[1] = CH_LBRK;
        bytes_d[2] = letter;
        if (letter == CH_THREE) begin
          bytes_d[3] = CH_TILDE;
          n_res      = 3'd4;
        end else begin
          n_res = 3'd3;
        end
      end
    end else if (in_byte_q < SC_TABLE_END && ascii != 8'h00) begin
      bytes_d[0] = ascii;
      n_res      = 3'd1;
    end
  end

  // Output run register
  logic              run_valid_q;
  event_kind_e       run_kind_q;
  logic [BYTE_W-1:0] run_bytes_q [4];
  logic [1:0]        run_last_q;
  logic [1:0]        run_pos_q;
  logic [TERM_W-1:0] run_term_q;
  logic              out_xfer;
  logic              run_done;
  logic              run_free;
  logic              load;

  assign out_xfer = run_valid_q && !out_stall_i;
  assign run_done = out_xfer && (run_pos_q == run_last_q);
  assign run_free = !run_valid_q || run_done;
  assign go       = in_valid_q && ((n_res == 3'd0) || run_free);
  assign load     = go && (n_res != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      ctrl_q   <= 1'b0;
      alt_q    <= 1'b0;
      prefix_q <= 1'b0;
      term_q   <= '0;
    end else if (go) begin
      shift_q  <= shift_d;
      ctrl_q   <= ctrl_d;
      alt_q    <= alt_d;
      prefix_q <= prefix_d;
      term_q   <= term_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_pos_q   <= '0;
    end else if (load) begin
      run_valid_q <= 1'b1;
      run_pos_q   <= '0;
    end else if (run_done) begin
      run_valid_q <= 1'b0;
    end else if (out_xfer) begin
      run_pos_q <= run_pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      run_kind_q  <= kind_d;
      run_bytes_q <= bytes_d;
      run_last_q  <= 2'(n_res - 3'd1);
      run_term_q  <= term_d;
    end
  end

  assign out_valid_o      = run_valid_q;
  assign event_kind_o     = run_kind_q;
  assign key_byte_o       = run_bytes_q[run_pos_q];
  assign terminal_index_o = run_term_q;
  assign last_of_run_o    = (run_pos_q == run_last_q);

endmodule

`default_nettype wire

[hdl/ps2kd_checker.sv]
// Port-level checker for the PS/2 scancode key decoder, with its bind.
// Depends on ps2kd_pkg and attaches to ps2_scancode_key_decoder_unit.
`default_nettype none

module ps2kd_checker #(
  parameter int unsigned TERMINALS = ps2kd_pkg::TERMINALS_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [1:0]                    event_kind_o,
  input wire logic [ps2kd_pkg::BYTE_W-1:0]  key_byte_o,
  input wire logic [ps2kd_pkg::TERM_W-1:0]  terminal_index_o,
  input wire logic                          last_of_run_o
);
  import ps2kd_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(key_byte_o) && $stable(terminal_index_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // Terminal index of a valid result is in range
  a_term_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(terminal_index_o) < TERMINALS))
    else $error("terminal index out of range");

  // Switch and scroll results are single, with a zero byte
  a_non_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != EV_KEY) |-> last_of_run_o && (key_byte_o == '0))
    else $error("non-key result malformed");

  // A run continues without a gap, on the same terminal
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=>
      out_valid_o && $stable(terminal_index_o) && (event_kind_o == EV_KEY))
    else $error("escape run broken");

endmodule

bind ps2_scancode_key_decoder_unit ps2kd_checker #(.TERMINALS(TERMINALS)) u_ps2kd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .event_kind_o     (event_kind_o),
  .key_byte_o       (key_byte_o),
  .terminal_index_o (terminal_index_o),
  .last_of_run_o    (last_of_run_o)
);

`default_nettype wire
